@@ rtl/oskm_pkg.sv @@
// Shared types, constants and helper functions of the sorted multiset block.
package oskm_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OCC_W    = 11;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned APB_AW   = 2;
  localparam int unsigned APB_DW   = 32;

  localparam logic [APB_AW-1:0] ADDR_MIN_THRESHOLD = '0;

  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_ADD    = 2'd1,
    OP_SUB    = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_IDLE    = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_ADJUST  = 3'd2,
    CMD_ROTATE  = 3'd3,
    CMD_SHIFT   = 3'd4,
    CMD_RDLOAD  = 3'd5,
    CMD_RDSHIFT = 3'd6
  } cell_cmd_e;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    cell_cmd_e              cmd;
    data_t                  operand;
    logic [CNT_W-1:0]       count;
    logic [IDX_W-1:0]       arg_idx;
  } cell_ctl_t;

  // Flipping the sign bit makes an unsigned compare order signed values.
  function automatic data_t key_of(data_t v);
    key_of = {~v[DATA_W-1], v[DATA_W-2:0]};
  endfunction

  // True when adding delta to the biased key of v carries out, i.e. v wraps.
  function automatic logic add_carry(data_t v, data_t delta);
    logic [DATA_W:0] sum;
    sum       = {1'b0, key_of(v)} + {1'b0, delta};
    add_carry = sum[DATA_W];
  endfunction

endpackage

@@ rtl/oskm_if.sv @@
// Valid/ready stream interfaces for the command and result channels.
interface oskm_in_if;
  import oskm_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic signed [31:0]  value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface oskm_out_if;
  import oskm_pkg::*;

  logic                valid;
  logic                ready;
  logic signed [31:0]  kth_value;
  logic                kth_valid;
  logic [31:0]         evicted_total;
  logic [OCC_W-1:0]    occupancy;
  logic                insert_dropped;

  modport source (output valid, output kth_value, output kth_valid, output evicted_total,
                  output occupancy, output insert_dropped, input ready);
  modport sink   (input valid, input kth_value, input kth_valid, input evicted_total,
                  input occupancy, input insert_dropped, output ready);
endinterface

@@ rtl/oskm_cell.sv @@
// One storage cell of the sorted row: entry, wrap flag and read-out stage.
module oskm_cell (
  input  logic                          clk_i,
  input  logic [oskm_pkg::IDX_W-1:0]    idx_i,
  input  oskm_pkg::cell_ctl_t           ctl_i,
  input  oskm_pkg::data_t               prev_val_i,
  input  logic                          prev_gt_i,
  input  oskm_pkg::data_t               next_val_i,
  input  logic                          next_wrap_i,
  input  oskm_pkg::data_t               next_rd_i,
  input  oskm_pkg::data_t               head_val_i,
  input  logic                          head_wrap_i,
  output oskm_pkg::data_t               val_o,
  output logic                          wrap_o,
  output oskm_pkg::data_t               rd_o,
  output logic                          gt_o
);
  import oskm_pkg::*;

  data_t val_q, val_d;
  logic  wrap_q, wrap_d;
  data_t rd_q, rd_d;
  logic  is_empty;
  logic  is_arg;

  // Cells at or beyond the fill level act as larger than any value.
  assign is_empty = ({1'b0, idx_i} >= ctl_i.count);
  assign is_arg   = (idx_i == ctl_i.arg_idx);
  assign gt_o     = is_empty || (key_of(val_q) > key_of(ctl_i.operand));

  always_comb begin
    val_d  = val_q;
    wrap_d = wrap_q;
    rd_d   = rd_q;
    unique case (ctl_i.cmd)
      CMD_IDLE: begin
      end
      CMD_INSERT: begin
        if (gt_o) begin
          val_d = prev_gt_i ? prev_val_i : ctl_i.operand;
        end
      end
      CMD_ADJUST: begin
        val_d  = val_q + ctl_i.operand;
        wrap_d = add_carry(val_q, ctl_i.operand);
      end
      CMD_ROTATE: begin
        if (is_arg) begin
          val_d  = head_val_i;
          wrap_d = head_wrap_i;
        end else begin
          val_d  = next_val_i;
          wrap_d = next_wrap_i;
        end
      end
      CMD_SHIFT: begin
        val_d = next_val_i;
      end
      CMD_RDLOAD: begin
        rd_d = is_arg ? val_q : next_rd_i;
      end
      CMD_RDSHIFT: begin
        rd_d = next_rd_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    wrap_q <= wrap_d;
    rd_q   <= rd_d;
  end

  assign val_o  = val_q;
  assign wrap_o = wrap_q;
  assign rd_o   = rd_q;

endmodule

@@ rtl/oskm_ctrl.sv @@
// Sequencer that drives the cell row, tracks counters and holds the result beat.
module oskm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  oskm_in_if.sink               in_i,
  oskm_out_if.source            res_o,
  input  oskm_pkg::data_t       thr_i,
  input  oskm_pkg::data_t       head_val_i,
  input  logic                  head_wrap_i,
  input  oskm_pkg::data_t       head_rd_i,
  output oskm_pkg::cell_ctl_t   ctl_o
);
  import oskm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ROTATE = 5'b00010,
    ST_EVICT  = 5'b00100,
    ST_READ   = 5'b01000,
    ST_RESP   = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [CNT_W-1:0]  count_q, count_d;
  data_t             evict_q, evict_d;
  data_t             max_q, max_d;
  logic [IDX_W-1:0]  steps_q, steps_d;
  data_t             kth_q, kth_d;
  logic              kvalid_q, kvalid_d;
  logic              drop_q, drop_d;
  logic              out_vld_q, out_vld_d;
  data_t             out_kth_q;
  logic              out_kvalid_q;
  data_t             out_evict_q;
  logic [CNT_W-1:0]  out_count_q;
  logic              out_drop_q;
  logic              load_out;

  logic              accept;
  op_e               op_in;
  data_t             v_in;
  data_t             delta;
  logic              carry_any;
  logic              carry_all;
  logic              rank_ok;
  logic [CNT_W-1:0]  rank_pos;
  logic [CNT_W-1:0]  last_pos;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign op_in      = op_e'(in_i.op);
  assign v_in       = data_t'(in_i.value);
  assign delta      = (op_in == OP_SUB) ? (data_t'(0) - v_in) : v_in;
  assign carry_any  = (count_q != '0) && add_carry(max_q, delta);
  assign carry_all  = add_carry(head_val_i, delta);
  assign rank_ok    = !v_in[DATA_W-1] && (v_in != '0) &&
                      (v_in <= DATA_W'(count_q));
  assign rank_pos   = count_q - CNT_W'(v_in);
  assign last_pos   = count_q - CNT_W'(1);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    count_d  = count_q;
    evict_d  = evict_q;
    max_d    = max_q;
    steps_d  = steps_q;
    kth_d    = kth_q;
    kvalid_d = kvalid_q;
    drop_d   = drop_q;
    load_out = 1'b0;

    ctl_o.cmd     = CMD_IDLE;
    ctl_o.operand = v_in;
    ctl_o.count   = count_q;
    ctl_o.arg_idx = last_pos[IDX_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d     = op_in;
          kth_d    = '0;
          kvalid_d = 1'b0;
          drop_d   = 1'b0;
          state_d  = ST_RESP;
          unique case (op_in)
            OP_INSERT: begin
              if (key_of(v_in) >= key_of(thr_i)) begin
                if (count_q == CNT_W'(CAPACITY)) begin
                  drop_d = 1'b1;
                end else begin
                  ctl_o.cmd = CMD_INSERT;
                  count_d   = count_q + CNT_W'(1);
                  if ((count_q == '0) || (key_of(v_in) > key_of(max_q))) begin
                    max_d = v_in;
                  end
                end
              end
            end
            OP_ADD, OP_SUB: begin
              ctl_o.cmd     = CMD_ADJUST;
              ctl_o.operand = delta;
              if (carry_any && !carry_all) begin
                state_d = ST_ROTATE;
              end else begin
                max_d = max_q + delta;
                if (op_in == OP_SUB) begin
                  state_d = ST_EVICT;
                end
              end
            end
            OP_QUERY: begin
              if (rank_ok) begin
                ctl_o.cmd     = CMD_RDLOAD;
                ctl_o.arg_idx = rank_pos[IDX_W-1:0];
                steps_d       = rank_pos[IDX_W-1:0];
                state_d       = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ROTATE: begin
        // The first wrapped entry reaching the head ends the rotation.
        if (head_wrap_i) begin
          state_d = (op_q == OP_SUB) ? ST_EVICT : ST_RESP;
        end else begin
          ctl_o.cmd = CMD_ROTATE;
          max_d     = head_val_i;
        end
      end
      ST_EVICT: begin
        if ((count_q != '0) && (key_of(head_val_i) < key_of(thr_i))) begin
          ctl_o.cmd = CMD_SHIFT;
          count_d   = count_q - CNT_W'(1);
          evict_d   = evict_q + data_t'(1);
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_READ: begin
        if (steps_q == '0) begin
          kth_d    = head_rd_i;
          kvalid_d = 1'b1;
          state_d  = ST_RESP;
        end else begin
          ctl_o.cmd = CMD_RDSHIFT;
          steps_d   = steps_q - IDX_W'(1);
        end
      end
      ST_RESP: begin
        if (!out_vld_q || res_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      evict_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      evict_q   <= evict_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    max_q    <= max_d;
    steps_q  <= steps_d;
    kth_q    <= kth_d;
    kvalid_q <= kvalid_d;
    drop_q   <= drop_d;
    if (load_out) begin
      out_kth_q    <= kth_q;
      out_kvalid_q <= kvalid_q;
      out_evict_q  <= evict_q;
      out_count_q  <= count_q;
      out_drop_q   <= drop_q;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.kth_value      = out_kth_q;
  assign res_o.kth_valid      = out_kvalid_q;
  assign res_o.evicted_total  = out_evict_q;
  assign res_o.occupancy      = OCC_W'(out_count_q);
  assign res_o.insert_dropped = out_drop_q;

endmodule

@@ rtl/offset_sorted_multiset_kth.sv @@
// Top level: threshold register, the row of sorted cells and the sequencer.
//
// This block keeps up to CAPACITY signed 32-bit values in ascending order in a
// row of cells, one value per cell, and answers one result beat for every command
// beat. An insert below the minimum threshold is ignored; an insert into a full
// store is dropped and flagged. Add and subtract change every stored value at once
// with 32-bit wraparound; values that wrap are moved back into order by rotating
// the row one cell per cycle, and a subtract then evicts entries below the
// threshold one per cycle from the low end. A query for the k-th largest value
// moves the chosen entry down a read-out chain one cell per cycle to the head.
// A new command is taken only when the previous one has finished, while its result
// may still wait in the output register. The threshold is written through the APB
// port at byte address 0 and is to be changed only while the block is idle.
module offset_sorted_multiset_kth (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  oskm_in_if.sink                       in_i,
  oskm_out_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [oskm_pkg::APB_AW-1:0]   paddr,
  input  logic [oskm_pkg::APB_DW-1:0]   pwdata,
  output logic [oskm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import oskm_pkg::*;

  data_t     thr_q, thr_d;
  logic      thr_we;
  cell_ctl_t ctl;

  data_t     cell_val  [CAPACITY];
  logic      cell_wrap [CAPACITY];
  data_t     cell_rd   [CAPACITY];
  logic      cell_gt   [CAPACITY];

  // Configuration port: pready held high, threshold register only.
  assign pready = 1'b1;
  assign thr_we = psel && penable && pwrite && pready && (paddr == ADDR_MIN_THRESHOLD);
  assign thr_d  = thr_we ? data_t'(pwdata) : thr_q;
  assign prdata = (paddr == ADDR_MIN_THRESHOLD) ? APB_DW'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else begin
      thr_q <= thr_d;
    end
  end

  // The row of cells. Cell 0 holds the smallest entry and is the head that the
  // sequencer watches; each cell sees its lower and upper neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    data_t prev_val;
    logic  prev_gt;
    data_t next_val;
    logic  next_wrap;
    data_t next_rd;

    if (i == 0) begin : g_first
      assign prev_val = '0;
      assign prev_gt  = 1'b0;
    end else begin : g_mid_lo
      assign prev_val = cell_val[i-1];
      assign prev_gt  = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_val  = '0;
      assign next_wrap = 1'b0;
      assign next_rd   = '0;
    end else begin : g_mid_hi
      assign next_val  = cell_val[i+1];
      assign next_wrap = cell_wrap[i+1];
      assign next_rd   = cell_rd[i+1];
    end

    oskm_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (IDX_W'(i)),
      .ctl_i       (ctl),
      .prev_val_i  (prev_val),
      .prev_gt_i   (prev_gt),
      .next_val_i  (next_val),
      .next_wrap_i (next_wrap),
      .next_rd_i   (next_rd),
      .head_val_i  (cell_val[0]),
      .head_wrap_i (cell_wrap[0]),
      .val_o       (cell_val[i]),
      .wrap_o      (cell_wrap[i]),
      .rd_o        (cell_rd[i]),
      .gt_o        (cell_gt[i])
    );
  end

  oskm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_o       (res_o),
    .thr_i       (thr_q),
    .head_val_i  (cell_val[0]),
    .head_wrap_i (cell_wrap[0]),
    .head_rd_i   (cell_rd[0]),
    .ctl_o       (ctl)
  );

endmodule

@@ tb/sv/tb_offset_sorted_multiset_kth.sv @@
// Self-checking testbench for the sorted multiset block with shared offset and k-th query.
module tb_offset_sorted_multiset_kth;
  import oskm_pkg::*;

  // Field extremes: the value field spans -INT_MAX .. INT_MAX.
  localparam int VAL_MAX      = 2147483647;
  localparam int VAL_MIN      = -2147483647;
  localparam int RANDOM_ITEMS = 430;
  // The slowest commands are full-store rotations and evictions, and the random
  // rounds keep the store below about 110 entries. The limit leaves a wide
  // margin over the run that this gives.
  localparam int CYCLE_LIMIT  = 1200000;
  localparam int TAIL_CYCLES  = 100;

  // One predicted result beat, with the block's field widths.
  typedef struct packed {
    logic signed [31:0] kth;
    logic               valid;
    logic [31:0]        evicted;
    logic [OCC_W-1:0]   occ;
    logic               dropped;
  } ms_result_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  oskm_in_if  cmd_if ();
  oskm_out_if res_if ();

  offset_sorted_multiset_kth uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (cmd_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the block's state. Values are kept as signed ints in
  // ascending order, so int arithmetic gives the same 32-bit wraparound.
  int          ms_vals [CAPACITY];
  int          ms_count;
  logic [31:0] ms_evicted;
  int          ms_floor;

  // Results owed by the block, oldest first.
  ms_result_t  reports_due [$];
  ms_result_t  oldest_due;

  int mismatches = 0;
  int cycles     = 0;
  int beats_seen = 0;
  int burst_left = 1;
  int hold_req   = 0;
  int hold_left  = 0;
  int seg_left   = 0;
  int rx_mode    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycles++;

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    wait (cycles == CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // The input range has no -2^31, so generated values that land there are
  // moved one step up.
  function automatic int fit_range(int x);
    return (x == VAL_MIN - 1) ? VAL_MIN : x;
  endfunction

  // Adding the same amount to every entry of a sorted list modulo 2^32 gives a
  // rotation of a sorted list: the entries that wrapped form one run, and
  // moving the run after the break to the front restores ascending order.
  function automatic void offset_all(int d);
    int rotated [$];
    int brk;
    brk = 0;
    for (int i = 0; i < ms_count; i++) ms_vals[i] += d;
    for (int i = 1; i < ms_count; i++) begin
      if (ms_vals[i] < ms_vals[i-1]) begin
        brk = i;
        break;
      end
    end
    if (brk != 0) begin
      for (int i = brk; i < ms_count; i++) rotated.push_back(ms_vals[i]);
      for (int i = 0; i < brk; i++) rotated.push_back(ms_vals[i]);
      for (int i = 0; i < ms_count; i++) ms_vals[i] = rotated[i];
    end
  endfunction

  // Entries below the threshold all sit at the low end after a subtract.
  function automatic void evict_below_floor();
    int n;
    n = 0;
    while (n < ms_count && ms_vals[n] < ms_floor) n++;
    if (n != 0) begin
      for (int i = 0; i < ms_count - n; i++) ms_vals[i] = ms_vals[i+n];
      ms_count   -= n;
      ms_evicted += n;
    end
  endfunction

  // Applies one command to the shadow state and returns the beat it causes.
  function automatic ms_result_t multiset_apply(op_e op, int v);
    ms_result_t r;
    int         pos;
    r = '0;
    case (op)
      OP_INSERT: begin
        // Below the threshold the insert is ignored without a flag; only a
        // full store raises the drop flag.
        if (v >= ms_floor) begin
          if (ms_count >= int'(CAPACITY)) begin
            r.dropped = 1'b1;
          end else begin
            pos = ms_count;
            while (pos > 0 && ms_vals[pos-1] > v) begin
              ms_vals[pos] = ms_vals[pos-1];
              pos--;
            end
            ms_vals[pos] = v;
            ms_count++;
          end
        end
      end
      OP_ADD: offset_all(v);
      OP_SUB: begin
        offset_all(-v);
        evict_below_floor();
      end
      OP_QUERY: begin
        // The rank is signed; anything outside 1..occupancy gives zero.
        if (v >= 1 && v <= ms_count) begin
          r.kth   = ms_vals[ms_count - v];
          r.valid = 1'b1;
        end
      end
    endcase
    r.evicted = ms_evicted;
    r.occ     = OCC_W'(ms_count);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(string msg);
    mismatches++;
    $display("ERROR cycle %0d: %s", cycles, msg);
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      note_mismatch($sformatf("beat %0d %s: got 0x%08h, expected 0x%08h",
                              beats_seen, name, got, want));
  endtask

  // Result side: checks every accepted beat against the oldest prediction and
  // then drives ready for the next cycle. A requested hold-off takes priority;
  // otherwise ready follows a randomly chosen stall mode that changes over the run:
  // always ready, coin flip, mostly stalled, or a fixed duty pattern.
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      beats_seen++;
      if (reports_due.size() == 0) begin
        note_mismatch($sformatf("beat %0d arrived with no command outstanding", beats_seen));
      end else begin
        oldest_due = reports_due.pop_front();
        compare_field("kth_value",      res_if.kth_value,      oldest_due.kth);
        compare_field("kth_valid",      32'(res_if.kth_valid), 32'(oldest_due.valid));
        compare_field("evicted_total",  res_if.evicted_total,  oldest_due.evicted);
        compare_field("occupancy",      32'(res_if.occupancy), 32'(oldest_due.occ));
        compare_field("insert_dropped", 32'(res_if.insert_dropped),
                      32'(oldest_due.dropped));
      end
    end
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        rx_mode  = $urandom_range(0, 3);
        seg_left = $urandom_range(20, 200);
      end
      seg_left--;
      case (rx_mode)
        0:       res_if.ready <= 1'b1;
        1:       res_if.ready <= 1'($urandom_range(0, 1));
        2:       res_if.ready <= ($urandom_range(0, 5) == 0);
        default: res_if.ready <= ((seg_left % 7) < 4);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  // Offers one command beat and waits for it to be taken. The prediction is
  // made at the accepting edge. Commands go out in bursts; at the end of a
  // burst valid drops for a short random gap. Within a burst valid stays high
  // so the next call simply replaces the payload.
  task automatic send_cmd(op_e op, int v);
    cmd_if.valid <= 1'b1;
    cmd_if.op    <= op;
    cmd_if.value <= v;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    reports_due.push_back(multiset_apply(op, v));
    burst_left--;
    if (burst_left <= 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
  endtask

  // Stops offering commands and waits until every owed beat has come back.
  // Each command yields exactly one beat, so the block is idle after that.
  task automatic quiet_and_drain();
    cmd_if.valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
  endtask

  // Writes the threshold over APB while the block is idle, then reads it back.
  task automatic write_floor(int v);
    quiet_and_drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MIN_THRESHOLD;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    ms_floor = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    compare_field("threshold readback", prdata, v);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // With the threshold at INT_MAX, one subtract of 1 evicts everything except
  // entries that wrap from -2^31 to INT_MAX; a second subtract evicts those.
  task automatic empty_store();
    write_floor(VAL_MAX);
    send_cmd(OP_SUB, 1);
    send_cmd(OP_SUB, 1);
  endtask

  // ---------------------------------------------------------------------------
  // Random field values
  // ---------------------------------------------------------------------------

  function automatic int pick_word();
    case ($urandom_range(0, 4))
      0: return fit_range(int'($urandom));
      1: begin
        case ($urandom_range(0, 4))
          0:       return VAL_MAX;
          1:       return VAL_MIN;
          2:       return 0;
          3:       return 1;
          default: return -1;
        endcase
      end
      2: return int'($urandom_range(0, 2000)) - 1000;
      // Around the threshold, mostly just above it.
      3: return fit_range(ms_floor + int'($urandom_range(0, 64)) - 8);
      // A copy of a stored value, to build up duplicates.
      default: begin
        if (ms_count == 0) return fit_range(int'($urandom));
        return fit_range(ms_vals[$urandom_range(0, ms_count - 1)]);
      end
    endcase
  endfunction

  function automatic int pick_amount();
    case ($urandom_range(0, 7))
      0, 1, 2: return int'($urandom_range(0, 300));
      3:       return fit_range(int'($urandom));
      4: begin
        case ($urandom_range(0, 2))
          0:       return VAL_MAX;
          1:       return VAL_MIN;
          default: return 0;
        endcase
      end
      // Just enough to push a chosen entry past INT_MAX, so that part of the
      // store wraps on an add (and on a subtract, the mirror case).
      default: begin
        if (ms_count == 0) return int'($urandom_range(0, 300));
        return fit_range(VAL_MAX - ms_vals[$urandom_range(0, ms_count - 1)] + 1);
      end
    endcase
  endfunction

  function automatic int pick_rank();
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return -1;
      3: return fit_range(int'($urandom));
      default: return int'($urandom_range(0, ms_count + 1));
    endcase
  endfunction

  function automatic int pick_floor();
    case ($urandom_range(0, 4))
      0:       return fit_range(int'($urandom));
      1:       return int'($urandom_range(0, 2000)) - 1000;
      2:       return VAL_MIN;
      3:       return VAL_MAX - int'($urandom_range(0, 5000));
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // The threshold is 0 out of reset.
  task automatic test_insert_floor();
    send_cmd(OP_INSERT, 0);        // equal to the threshold: kept
    send_cmd(OP_INSERT, -1);       // below the threshold: ignored, no flag
    send_cmd(OP_INSERT, VAL_MIN);
    send_cmd(OP_INSERT, VAL_MAX);
    send_cmd(OP_INSERT, 5);
    send_cmd(OP_INSERT, 5);
  endtask

  // The store now holds 0, 5, 5, INT_MAX.
  task automatic test_query_ranks();
    send_cmd(OP_QUERY, 1);
    send_cmd(OP_QUERY, 2);
    send_cmd(OP_QUERY, 4);
    send_cmd(OP_QUERY, 5);         // one past the occupancy
    send_cmd(OP_QUERY, 0);
    send_cmd(OP_QUERY, -1);
    send_cmd(OP_QUERY, VAL_MAX);
    send_cmd(OP_QUERY, VAL_MIN);
  endtask

  // Adds and subtracts that carry entries across the signed limits, with the
  // threshold at -INT_MAX, the lowest threshold that the bench uses.
  task automatic test_wrap_evict();
    write_floor(VAL_MIN);
    send_cmd(OP_ADD, 1);           // INT_MAX wraps to -2^31 and moves to the front
    send_cmd(OP_QUERY, 4);
    send_cmd(OP_SUB, 2);           // -2^31 wraps back to the top
    send_cmd(OP_SUB, VAL_MAX);     // the lowest entry lands on -2^31 and is evicted
    send_cmd(OP_ADD, VAL_MIN);
    send_cmd(OP_QUERY, 1);
    send_cmd(OP_SUB, VAL_MIN);     // a negative amount raises every entry
    send_cmd(OP_QUERY, 1);
    send_cmd(OP_QUERY, 3);
    empty_store();
  endtask

  // Fills the store to capacity while the result side holds off, so the block
  // backs up and stalls its input. Then drops on a full store, queries at the
  // ends of the rank range, and a partial wrap and eviction over a full row.
  task automatic test_full_store();
    write_floor(-1000);
    hold_req = 400;
    repeat (CAPACITY) send_cmd(OP_INSERT, int'($urandom_range(0, 1000000)) - 1000);
    send_cmd(OP_INSERT, 7);        // full: dropped and flagged
    send_cmd(OP_INSERT, VAL_MAX);
    send_cmd(OP_INSERT, -2000);    // full but below the threshold: no flag
    send_cmd(OP_QUERY, 1);
    send_cmd(OP_QUERY, CAPACITY);
    send_cmd(OP_QUERY, CAPACITY + 1);
    send_cmd(OP_QUERY, CAPACITY / 2);
    send_cmd(OP_ADD, 1);
    send_cmd(OP_ADD, VAL_MAX - 500000);  // the upper part wraps
    send_cmd(OP_QUERY, 1);
    send_cmd(OP_SUB, 1000);        // the wrapped part is evicted
    send_cmd(OP_QUERY, 1);
    empty_store();
  endtask

  // Rounds of mixed commands, each under its own threshold, each ending with
  // the store emptied so that the row stays short and the run stays fast.
  task automatic test_random_rounds();
    int sent;
    int n;
    int sel;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      write_floor(pick_floor());
      n = $urandom_range(40, 110);
      repeat (n) begin
        sel = $urandom_range(0, 99);
        if (sel < 40)      send_cmd(OP_INSERT, pick_word());
        else if (sel < 52) send_cmd(OP_ADD, pick_amount());
        else if (sel < 64) send_cmd(OP_SUB, pick_amount());
        else               send_cmd(OP_QUERY, pick_rank());
      end
      empty_store();
      sent += n + 2;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n        <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    cmd_if.valid <= 1'b0;
    cmd_if.op    <= OP_INSERT;
    cmd_if.value <= '0;
    ms_count   = 0;
    ms_evicted = '0;
    ms_floor   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_insert_floor();
    test_query_ranks();
    test_wrap_evict();
    test_full_store();
    test_random_rounds();

    // Let any stray beat show up before the verdict.
    quiet_and_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
